[rtl/swdc_pkg.sv]
`default_nettype none

package swdc_pkg;

   // Sample path widths
   localparam int SAMPLE_BITS = 10;
   localparam int SUM_W       = SAMPLE_BITS + 2;
   localparam int PROD_W      = 2 * SUM_W;

   // Divide by three as a multiply by ceil(2^RECIP_SHIFT / 3), exact for SUM_W-bit sums
   localparam int RECIP_SHIFT = SUM_W + 1;
   localparam logic [SUM_W-1:0] RECIP = SUM_W'(((2 ** RECIP_SHIFT) + 2) / 3);

   // Register widths
   localparam int THRESH_W    = 10;
   localparam int SPACING_W   = 8;
   localparam int HEARTBEAT_W = 16;
   localparam int CHECKS_W    = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CMP_W       = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_AWAKE_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIG_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIG_SPACING   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_SPACING    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEARTBEAT_TICKS  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECK_COUNT      = 3'd5;

   // Register reset values
   localparam logic [THRESH_W-1:0]    AWAKE_THRESHOLD_RST  = 10'd380;
   localparam logic [THRESH_W-1:0]    CONFIG_THRESHOLD_RST = 10'd920;
   localparam logic [SPACING_W-1:0]   CONFIG_SPACING_RST   = 8'd1;
   localparam logic [SPACING_W-1:0]   VALUE_SPACING_RST    = 8'd3;
   localparam logic [HEARTBEAT_W-1:0] HEARTBEAT_TICKS_RST  = 16'd28800;
   localparam logic [CHECKS_W-1:0]    CHECK_COUNT_RST      = 4'd10;

   localparam logic [HEARTBEAT_W-1:0] HEARTBEAT_MAX = '1;

   // Wake reason codes
   localparam logic [1:0] REASON_HEARTBEAT = 2'd0;
   localparam logic [1:0] REASON_CONFIG    = 2'd1;
   localparam logic [1:0] REASON_VALUE     = 2'd2;

endpackage

`default_nettype wire

[rtl/sensor_wake_debounce_controller_core.sv]
// Sensor wake debounce controller.
// One request per sensor tick carries three ADC samples (req_sample_a/b/c) on a
// valid/stall channel; the block averages them, runs the heartbeat counter and the
// config/value debounce sequencer, and returns one response per request on the
// rsp_ channel: wake pulse, wake reason, expected level and sticky config flag.
// Registers are written through csr_write_enable/csr_index/csr_write_data; the user
// must write them only while no request is in flight, as the block does not enforce it.
// Path: a request accepted into the input register has its response loaded into the
// result register when that register advances, and it is offered from then on.
// Throughput: one request per cycle while not stalled; the average, the debounce
// step and the state update all fit in one pass between input and result registers.
// Stall: when rsp_stall holds a full result register, the input register holds its
// request and req_stall rises once the input register is full too; nothing is lost.
// Reset (synchronous, active high) empties both registers, restores the register
// defaults, returns the sequencer to idle with expected level high, heartbeat count
// zero and config flag clear.
`default_nettype none

module sensor_wake_debounce_controller_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [swdc_pkg::SAMPLE_BITS-1:0]    req_sample_a,
   input  wire logic [swdc_pkg::SAMPLE_BITS-1:0]    req_sample_b,
   input  wire logic [swdc_pkg::SAMPLE_BITS-1:0]    req_sample_c,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_wake,
   output logic [1:0]                               rsp_wake_reason,
   output logic                                     rsp_expected_level,
   output logic                                     rsp_config_flag,
   // register write port
   input  wire logic                                csr_write_enable,
   input  wire logic [swdc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [swdc_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_CONFIG,
      MODE_VALUE
   } mode_type;

   // Configuration registers
   logic [swdc_pkg::THRESH_W-1:0]    awake_threshold_ff;
   logic [swdc_pkg::THRESH_W-1:0]    config_threshold_ff;
   logic [swdc_pkg::SPACING_W-1:0]   config_spacing_ff;
   logic [swdc_pkg::SPACING_W-1:0]   value_spacing_ff;
   logic [swdc_pkg::HEARTBEAT_W-1:0] heartbeat_ticks_ff;
   logic [swdc_pkg::CHECKS_W-1:0]    check_count_ff;

   // Input register
   logic                             in_valid_ff;
   logic [swdc_pkg::SAMPLE_BITS-1:0] in_sample_a_ff;
   logic [swdc_pkg::SAMPLE_BITS-1:0] in_sample_b_ff;
   logic [swdc_pkg::SAMPLE_BITS-1:0] in_sample_c_ff;

   // Sequencer state
   mode_type                         mode_ff, mode_in;
   logic [swdc_pkg::CHECKS_W-1:0]    checks_done_ff, checks_done_in;
   logic [swdc_pkg::SPACING_W-1:0]   spacing_count_ff, spacing_count_in;
   logic [swdc_pkg::HEARTBEAT_W-1:0] heartbeat_count_ff, heartbeat_count_in;
   logic                             level_expected_ff, level_expected_in;
   logic                             config_set_ff, config_set_in;

   // Result register
   logic                             rsp_valid_ff;
   logic                             rsp_wake_ff, wake_in;
   logic [1:0]                       rsp_wake_reason_ff, reason_in;

   // Datapath
   logic                             advance;
   logic                             load;
   logic [swdc_pkg::SUM_W-1:0]       sum;
   logic [swdc_pkg::PROD_W-1:0]      prod;
   logic [swdc_pkg::SAMPLE_BITS-1:0] avg;
   logic [swdc_pkg::CMP_W-1:0]       avg_ext;
   logic                             config_hit;
   logic                             level_bit;
   logic                             value_hit;
   logic [swdc_pkg::SPACING_W-1:0]   spacing;
   logic [swdc_pkg::SPACING_W-1:0]   spacing_next;
   logic [swdc_pkg::CHECKS_W-1:0]    checks_next;
   logic                             check_pass;

   // Result register frees up when empty or when its response leaves this edge
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign load      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_wake           = rsp_wake_ff;
   assign rsp_wake_reason    = rsp_wake_reason_ff;
   assign rsp_expected_level = level_expected_ff;
   assign rsp_config_flag    = config_set_ff;

   // Register writes; index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         awake_threshold_ff  <= swdc_pkg::AWAKE_THRESHOLD_RST;
         config_threshold_ff <= swdc_pkg::CONFIG_THRESHOLD_RST;
         config_spacing_ff   <= swdc_pkg::CONFIG_SPACING_RST;
         value_spacing_ff    <= swdc_pkg::VALUE_SPACING_RST;
         heartbeat_ticks_ff  <= swdc_pkg::HEARTBEAT_TICKS_RST;
         check_count_ff      <= swdc_pkg::CHECK_COUNT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            swdc_pkg::CSR_AWAKE_THRESHOLD:
               awake_threshold_ff <= csr_write_data[swdc_pkg::THRESH_W-1:0];
            swdc_pkg::CSR_CONFIG_THRESHOLD:
               config_threshold_ff <= csr_write_data[swdc_pkg::THRESH_W-1:0];
            swdc_pkg::CSR_CONFIG_SPACING:
               config_spacing_ff <= csr_write_data[swdc_pkg::SPACING_W-1:0];
            swdc_pkg::CSR_VALUE_SPACING:
               value_spacing_ff <= csr_write_data[swdc_pkg::SPACING_W-1:0];
            swdc_pkg::CSR_HEARTBEAT_TICKS:
               heartbeat_ticks_ff <= csr_write_data[swdc_pkg::HEARTBEAT_W-1:0];
            swdc_pkg::CSR_CHECK_COUNT:
               check_count_ff <= csr_write_data[swdc_pkg::CHECKS_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register: take a new request whenever it is empty or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_sample_a_ff <= req_sample_a;
         in_sample_b_ff <= req_sample_b;
         in_sample_c_ff <= req_sample_c;
      end
   end

   // Average: sum of three, then divide by three through a reciprocal multiply
   always_comb begin
      sum     = swdc_pkg::SUM_W'(in_sample_a_ff) + swdc_pkg::SUM_W'(in_sample_b_ff)
              + swdc_pkg::SUM_W'(in_sample_c_ff);
      prod    = swdc_pkg::PROD_W'(sum) * swdc_pkg::PROD_W'(swdc_pkg::RECIP);
      avg     = prod[swdc_pkg::RECIP_SHIFT +: swdc_pkg::SAMPLE_BITS];
      avg_ext = swdc_pkg::CMP_W'(avg);
      config_hit = avg_ext >= swdc_pkg::CMP_W'(config_threshold_ff);
      level_bit  = avg_ext >= swdc_pkg::CMP_W'(awake_threshold_ff);
      value_hit  = !config_hit && (level_bit == level_expected_ff);
   end

   // Sequencer step for the request in the input register
   always_comb begin
      mode_in            = mode_ff;
      checks_done_in     = checks_done_ff;
      spacing_count_in   = spacing_count_ff;
      heartbeat_count_in = heartbeat_count_ff;
      level_expected_in  = level_expected_ff;
      config_set_in      = config_set_ff;
      wake_in            = 1'b0;
      reason_in          = swdc_pkg::REASON_HEARTBEAT;

      spacing      = (mode_ff == MODE_CONFIG) ? config_spacing_ff : value_spacing_ff;
      if (spacing == '0) begin
         spacing = swdc_pkg::SPACING_W'(1);
      end
      spacing_next = spacing_count_ff + swdc_pkg::SPACING_W'(1);
      checks_next  = checks_done_ff + swdc_pkg::CHECKS_W'(1);
      check_pass   = (mode_ff == MODE_CONFIG) ? config_hit : value_hit;

      case (mode_ff)
         MODE_CONFIG, MODE_VALUE: begin
            spacing_count_in = spacing_next;
            if (spacing_next >= spacing) begin
               spacing_count_in = '0;
               if (!check_pass) begin
                  // failed check: drop the debounce without a wake
                  mode_in        = MODE_IDLE;
                  checks_done_in = '0;
               end else if (checks_next >= check_count_ff) begin
                  wake_in = 1'b1;
                  if (mode_ff == MODE_CONFIG) begin
                     reason_in     = swdc_pkg::REASON_CONFIG;
                     config_set_in = 1'b1;
                  end else begin
                     reason_in         = swdc_pkg::REASON_VALUE;
                     level_expected_in = !level_expected_ff;
                  end
                  heartbeat_count_in = '0;
                  mode_in            = MODE_IDLE;
                  checks_done_in     = '0;
               end else begin
                  checks_done_in = checks_next;
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            if (heartbeat_count_ff >= heartbeat_ticks_ff) begin
               wake_in            = 1'b1;
               heartbeat_count_in = '0;
            end else if (config_hit) begin
               mode_in          = MODE_CONFIG;
               checks_done_in   = '0;
               spacing_count_in = '0;
            end else if (value_hit) begin
               mode_in          = MODE_VALUE;
               checks_done_in   = '0;
               spacing_count_in = '0;
            end else if (heartbeat_count_ff != swdc_pkg::HEARTBEAT_MAX) begin
               heartbeat_count_in = heartbeat_count_ff + swdc_pkg::HEARTBEAT_W'(1);
            end
         end
      endcase
   end

   // State and result register advance together
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= MODE_IDLE;
         checks_done_ff     <= '0;
         spacing_count_ff   <= '0;
         heartbeat_count_ff <= '0;
         level_expected_ff  <= 1'b1;
         config_set_ff      <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         rsp_wake_ff        <= 1'b0;
         rsp_wake_reason_ff <= swdc_pkg::REASON_HEARTBEAT;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            mode_ff            <= mode_in;
            checks_done_ff     <= checks_done_in;
            spacing_count_ff   <= spacing_count_in;
            heartbeat_count_ff <= heartbeat_count_in;
            level_expected_ff  <= level_expected_in;
            config_set_ff      <= config_set_in;
            rsp_wake_ff        <= wake_in;
            rsp_wake_reason_ff <= reason_in;
         end
      end
   end

   // Input side backs up only behind a full input register
   assert property (@(posedge clock) disable iff (reset) req_stall |-> in_valid_ff)
      else $error("request stalled with empty input register");

   // Expected level flips only together with a value wake
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && level_expected_ff != $past(level_expected_ff))
         |-> (rsp_valid_ff && rsp_wake_ff && rsp_wake_reason_ff == swdc_pkg::REASON_VALUE))
      else $error("expected level changed without a value wake");

   // Config flag is sticky
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(config_set_ff)) |-> config_set_ff)
      else $error("config flag cleared outside reset");

   // Every wake clears the heartbeat counter
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(load) && $past(wake_in)) |-> (heartbeat_count_ff == '0))
      else $error("heartbeat count not cleared by wake");

   // Response holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid_ff) && $past(rsp_stall))
         |-> (rsp_valid_ff && $stable(rsp_wake_ff) && $stable(rsp_wake_reason_ff)))
      else $error("stalled response changed");

endmodule

`default_nettype wire
